FILE: src/rpcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_pkg
// Shared constants for the rolling pole curve point pipeline: fixed-point
// angle constants, CORDIC arctangent table and configuration register codes.
// ----------------------------------------------------------------------------
package rpcp_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
    localparam int TOLERANCE_LSB = 4;

    // CORDIC datapath width (Q2.30 plus headroom)
    localparam int CW = 34;

    localparam logic [26:0]          TWO_PI_Q24  = 27'd105414357;
    localparam logic [26:0]          PI_Q24      = 27'd52707178;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sh026DD3B6A;
    localparam logic signed [31:0]   ONE_Q24     = 32'sh01000000;

    // floor mod 2pi: bias by a whole number of turns, then reciprocal estimate
    localparam logic [40:0] MOD_BIAS  = 41'd549841286112;
    localparam logic [15:0] MOD_RECIP = 16'd41721;
    localparam int          MOD_SHIFT = 42;

    localparam logic [31:0] ATAN_Q30 [30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    localparam logic [2:0] CFG_HALF_PITCH      = 3'd0;
    localparam logic [2:0] CFG_CENTER_DISTANCE = 3'd1;
    localparam logic [2:0] CFG_OFFSETS         = 3'd2;
    localparam logic [2:0] CFG_PHASE           = 3'd3;
    localparam logic [2:0] CFG_RATE            = 3'd4;
    localparam logic [2:0] CFG_WINDOW_ONE      = 3'd5;
    localparam logic [2:0] CFG_WINDOW_TWO      = 3'd6;
    localparam logic [2:0] CFG_WINDOW_ENABLES  = 3'd7;

endpackage

FILE: src/rpcp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
// Returns cos and sin (Q2.30) of the folded angle, with the fold flag.
// ----------------------------------------------------------------------------
module rpcp_cordic (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [rpcp_pkg::CW-1:0] i_z,
    input  logic                           i_flip,
    output logic signed [rpcp_pkg::CW-1:0] o_x,
    output logic signed [rpcp_pkg::CW-1:0] o_y,
    output logic                           o_flip
);

    localparam int N  = rpcp_pkg::CORDIC_N;
    localparam int CW = rpcp_pkg::CW;

    logic signed [CW-1:0] r_x [N];
    logic signed [CW-1:0] r_y [N];
    logic signed [CW-1:0] r_z [N];
    logic                 r_f [N];
    logic signed [CW-1:0] n_x [N];
    logic signed [CW-1:0] n_y [N];
    logic signed [CW-1:0] n_z [N];
    logic                 n_f [N];

    always_comb begin
        logic signed [CW-1:0] xi, yi, zi, at;
        logic                 fi;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                xi = rpcp_pkg::GAIN_Q30;
                yi = '0;
                zi = i_z;
                fi = i_flip;
            end else begin
                xi = r_x[i-1];
                yi = r_y[i-1];
                zi = r_z[i-1];
                fi = r_f[i-1];
            end
            at = $signed({2'b00, rpcp_pkg::ATAN_Q30[i]});
            if (zi >= 0) begin
                n_x[i] = xi - (yi >>> i);
                n_y[i] = yi + (xi >>> i);
                n_z[i] = zi - at;
            end else begin
                n_x[i] = xi + (yi >>> i);
                n_y[i] = yi - (xi >>> i);
                n_z[i] = zi + at;
            end
            n_f[i] = fi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_f <= n_f;
        end
    end

    assign o_x    = r_x[N-1];
    assign o_y    = r_y[N-1];
    assign o_flip = r_f[N-1];

endmodule

FILE: src/rolling_pole_curve_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_pole_curve_point
// Evaluates one point of the rolling pole curve per time sample, with
// saturation flag and validity window check.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per clock cycle while the output is not
// held off (9 angle reduction stages, 24 CORDIC stages, 5 multiply/sum
// stages, then the output registers). Latency follows the CORDIC stage count. When the
// output transaction is held off, the whole pipeline holds and o_ready drops.
// Configuration writes take effect immediately and must only be issued while
// the pipeline is empty.
module rolling_pole_curve_point (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_time_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_in_window,
    output logic               o_clipped
);

    localparam int N     = rpcp_pkg::CORDIC_N;
    localparam int NV    = 14 + N;
    localparam int CW    = rpcp_pkg::CW;
    localparam int LANES = 3;

    typedef struct packed {
        logic                 flip;
        logic signed [CW-1:0] z;
    } t_fold;

    typedef struct packed {
        logic signed [39:0] w;
        logic signed [40:0] a;
        logic               tok;
        logic [LANES-1:0]   neg;
    } t_side;

    function automatic t_fold fold(input logic [26:0] r);
        logic signed [27:0]   s;
        logic signed [CW-1:0] z;
        t_fold                f;
        s = (r > rpcp_pkg::PI_Q24) ?
            $signed({1'b0, r}) - $signed({1'b0, rpcp_pkg::TWO_PI_Q24}) :
            $signed({1'b0, r});
        z = CW'(s) <<< 6;
        f.flip = 1'b0;
        f.z    = z;
        if (z > rpcp_pkg::HALF_PI_Q30) begin
            f.z    = z - rpcp_pkg::PI_Q30;
            f.flip = 1'b1;
        end else if (z < -rpcp_pkg::HALF_PI_Q30) begin
            f.z    = z + rpcp_pkg::PI_Q30;
            f.flip = 1'b1;
        end
        return f;
    endfunction

    // w above the window end is pulled down by whole turns: hi - ((hi - w) mod 2pi)
    function automatic logic win_ok(input logic en_bit, input logic neg,
                                    input logic [26:0] m, input logic signed [39:0] w,
                                    input logic [63:0] win);
        logic signed [31:0] lo, hi;
        logic signed [41:0] ws, tol;
        lo  = win[63:32];
        hi  = win[31:0];
        tol = 42'(rpcp_pkg::TOLERANCE_LSB);
        ws  = neg ? 42'(hi) - $signed({15'd0, m}) : 42'(w);
        return en_bit && (ws + tol >= 42'(lo)) && (ws - tol <= 42'(hi));
    endfunction

    function automatic logic [32:0] sat32(input logic signed [51:0] v);
        logic ov;
        ov = !((&v[51:31]) || (~|v[51:31]));
        if (!ov) begin
            return {1'b0, v[31:0]};
        end
        return v[51] ? {1'b1, 32'h80000000} : {1'b1, 32'h7FFFFFFF};
    endfunction

    // configuration
    logic signed [31:0] r_half_pitch, r_center_distance, r_phase, r_rate;
    logic [63:0]        r_offsets, r_window_one, r_window_two;
    logic [1:0]         r_window_enables;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_pitch      <= '0;
            r_center_distance <= '0;
            r_offsets         <= '0;
            r_phase           <= '0;
            r_rate            <= '0;
            r_window_one      <= '0;
            r_window_two      <= '0;
            r_window_enables  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpcp_pkg::CFG_HALF_PITCH:      r_half_pitch      <= i_cfg_data[31:0];
                rpcp_pkg::CFG_CENTER_DISTANCE: r_center_distance <= i_cfg_data[31:0];
                rpcp_pkg::CFG_OFFSETS:         r_offsets         <= i_cfg_data;
                rpcp_pkg::CFG_PHASE:           r_phase           <= i_cfg_data[31:0];
                rpcp_pkg::CFG_RATE:            r_rate            <= i_cfg_data[31:0];
                rpcp_pkg::CFG_WINDOW_ONE:      r_window_one      <= i_cfg_data;
                rpcp_pkg::CFG_WINDOW_TWO:      r_window_two      <= i_cfg_data;
                rpcp_pkg::CFG_WINDOW_ENABLES:  r_window_enables  <= i_cfg_data[1:0];
            endcase
        end
    end

    // handshake
    logic          en, in_acc;
    logic [NV-1:0] r_vld;
    logic          r_o_valid;

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;
    assign in_acc  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NV-2:0], in_acc};
            r_o_valid <= r_vld[NV-1];
        end
    end

    // angle and window reduction stages
    logic signed [63:0] r1_p;
    logic               r1_tok;
    logic signed [39:0] c_w;
    logic signed [31:0] c_hi1, c_hi2, c_xoff, c_yoff;
    t_side              r2_sd, r3_sd, r4_sd, r5_sd, r6_sd, r7_sd;
    logic signed [40:0] r2_v   [LANES];
    logic [40:0]        r3_b   [LANES];
    logic [40:0]        r4_b   [LANES];
    logic [40:0]        r5_b   [LANES];
    logic [56:0]        r4_prod[LANES];
    logic [41:0]        r5_qm  [LANES];
    logic [28:0]        r6_r   [LANES];
    logic [26:0]        r7_m   [LANES];
    logic [27:0]        c_dbl;
    logic [26:0]        r8_ra, r8_r2;
    logic signed [40:0] r8_a, r9_a;
    logic               r8_ok, r9_ok, c_ok1, c_ok2;
    t_fold              r9_f0, r9_f1;

    assign c_w    = r1_p[63:24];
    assign c_hi1  = r_window_one[31:0];
    assign c_hi2  = r_window_two[31:0];
    assign c_xoff = r_offsets[63:32];
    assign c_yoff = r_offsets[31:0];
    assign c_dbl  = {r7_m[0], 1'b0};
    assign c_ok1  = win_ok(r_window_enables[0], r7_sd.neg[1], r7_m[1], r7_sd.w,
                           r_window_one);
    assign c_ok2  = win_ok(r_window_enables[1], r7_sd.neg[2], r7_m[2], r7_sd.w,
                           r_window_two);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p   <= i_time_value * r_rate;
            r1_tok <= (i_time_value >= 0) && (i_time_value <= rpcp_pkg::ONE_Q24);

            r2_sd.w   <= c_w;
            r2_sd.a   <= 41'(r_phase) + 41'(c_w);
            r2_sd.tok <= r1_tok;
            r2_sd.neg <= {c_w > 40'(c_hi2), c_w > 40'(c_hi1),
                          (41'(r_phase) + 41'(c_w)) < 41'sd0};
            r2_v[0]   <= 41'(r_phase) + 41'(c_w);
            r2_v[1]   <= 41'(c_hi1) - 41'(c_w);
            r2_v[2]   <= 41'(c_hi2) - 41'(c_w);

            r3_sd <= r2_sd;
            r4_sd <= r3_sd;
            r5_sd <= r4_sd;
            r6_sd <= r5_sd;
            r7_sd <= r6_sd;
            for (int k = 0; k < LANES; k++) begin
                r3_b[k]    <= unsigned'(r2_v[k]) + rpcp_pkg::MOD_BIAS;
                r4_prod[k] <= r3_b[k] * rpcp_pkg::MOD_RECIP;
                r4_b[k]    <= r3_b[k];
                r5_qm[k]   <= r4_prod[k][56:rpcp_pkg::MOD_SHIFT] * rpcp_pkg::TWO_PI_Q24;
                r5_b[k]    <= r4_b[k];
                r6_r[k]    <= 29'({1'b0, r5_b[k]} - r5_qm[k]);
                r7_m[k]    <= (r6_r[k] >= {2'b00, rpcp_pkg::TWO_PI_Q24}) ?
                              27'(r6_r[k] - {2'b00, rpcp_pkg::TWO_PI_Q24}) : r6_r[k][26:0];
            end

            r8_ra <= r7_m[0];
            r8_r2 <= (c_dbl >= {1'b0, rpcp_pkg::TWO_PI_Q24}) ?
                     27'(c_dbl - {1'b0, rpcp_pkg::TWO_PI_Q24}) : c_dbl[26:0];
            r8_a  <= r7_sd.a;
            r8_ok <= r7_sd.tok && (c_ok1 || c_ok2 || r_window_enables == 2'b00);

            r9_f0 <= fold(r8_ra);
            r9_f1 <= fold(r8_r2);
            r9_a  <= r8_a;
            r9_ok <= r8_ok;
        end
    end

    // sine and cosine of a and 2a
    logic signed [CW-1:0] c_x0, c_y0, c_x1, c_y1;
    logic                 c_fl0, c_fl1;

    rpcp_cordic u_cordic_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_z    (r9_f0.z),
        .i_flip (r9_f0.flip),
        .o_x    (c_x0),
        .o_y    (c_y0),
        .o_flip (c_fl0)
    );

    rpcp_cordic u_cordic_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_z    (r9_f1.z),
        .i_flip (r9_f1.flip),
        .o_x    (c_x1),
        .o_y    (c_y1),
        .o_flip (c_fl1)
    );

    logic signed [40:0] r_cd_a  [N];
    logic               r_cd_ok [N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd_a[0]  <= r9_a;
            r_cd_ok[0] <= r9_ok;
            for (int i = 1; i < N; i++) begin
                r_cd_a[i]  <= r_cd_a[i-1];
                r_cd_ok[i] <= r_cd_ok[i-1];
            end
        end
    end

    // products and sums
    logic signed [CW-1:0] r_p1_ca, r_p1_sa, r_p1_c2, r_p1_s2;
    logic signed [CW-1:0] r_p2_ca, r_p2_sa, r_p2_c2;
    logic signed [40:0]   r_p1_a;
    logic signed [48:0]   r_p2_l;
    logic signed [65:0]   r_p3_dc, r_p3_ds, r_p3_hc;
    logic signed [56:0]   r_p3_hlo, r_p3_hhi;
    logic signed [80:0]   c_hl;
    logic signed [50:0]   r_p4_tx;
    logic signed [35:0]   r_p4_tdc, r_p4_ty, r_p4_tds;
    logic signed [51:0]   r_p5_x, r_p5_y;
    logic                 r_p1_ok, r_p2_ok, r_p3_ok, r_p4_ok, r_p5_ok;
    logic [32:0]          c_sx, c_sy;

    assign c_hl = (81'(r_p3_hhi) <<< 24) + 81'(r_p3_hlo);
    assign c_sx = sat32(r_p5_x);
    assign c_sy = sat32(r_p5_y);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_ca <= c_fl0 ? -c_x0 : c_x0;
            r_p1_sa <= c_fl0 ? -c_y0 : c_y0;
            r_p1_c2 <= c_fl1 ? -c_x1 : c_x1;
            r_p1_s2 <= c_fl1 ? -c_y1 : c_y1;
            r_p1_a  <= r_cd_a[N-1];
            r_p1_ok <= r_cd_ok[N-1];

            r_p2_l  <= (49'(r_p1_a) <<< 7) - 49'(r_p1_s2);
            r_p2_ca <= r_p1_ca;
            r_p2_sa <= r_p1_sa;
            r_p2_c2 <= r_p1_c2;
            r_p2_ok <= r_p1_ok;

            r_p3_dc  <= r_center_distance * r_p2_ca;
            r_p3_ds  <= r_center_distance * r_p2_sa;
            r_p3_hc  <= r_half_pitch * r_p2_c2;
            r_p3_hlo <= r_half_pitch * $signed({1'b0, r_p2_l[23:0]});
            r_p3_hhi <= r_half_pitch * $signed(r_p2_l[48:24]);
            r_p3_ok  <= r_p2_ok;

            r_p4_tx  <= c_hl[80:30];
            r_p4_tdc <= r_p3_dc[65:30];
            r_p4_ty  <= r_p3_hc[65:30];
            r_p4_tds <= r_p3_ds[65:30];
            r_p4_ok  <= r_p3_ok;

            r_p5_x  <= 52'(r_p4_tx) + 52'(r_p4_tdc) + 52'(c_xoff);
            r_p5_y  <= 52'(r_p4_ty) + 52'(r_p4_tds) + 52'(c_yoff);
            r_p5_ok <= r_p4_ok;

            o_point_x   <= c_sx[31:0];
            o_point_y   <= c_sy[31:0];
            o_clipped   <= c_sx[32] || c_sy[32];
            o_in_window <= r_p5_ok;
        end
    end

    assign o_valid = r_o_valid;

endmodule

FILE: src/rpcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_checker
// Port-level checks for the rolling pole curve point block, bound to the
// top level.
// ----------------------------------------------------------------------------
module rpcp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_point_x,
    input logic signed [31:0] o_point_y,
    input logic               o_clipped
);

    // held output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_x) && $stable(o_point_y))
        else $error("output transaction changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input side only waits on a full output register
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_point_x == 32'sh7FFFFFFF || o_point_x == 32'sh80000000 ||
             o_point_y == 32'sh7FFFFFFF || o_point_y == 32'sh80000000))
        else $error("clip flag without saturated coordinate");

endmodule

bind rolling_pole_curve_point rpcp_checker u_rpcp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y),
    .o_clipped (o_clipped)
);
